[design/hack_cpu_step_assert.svh]
// assertion macros for the hack cpu step block
`ifndef HACK_CPU_STEP_ASSERT_SVH
`define HACK_CPU_STEP_ASSERT_SVH

`ifndef SYNTHESIS
`define HCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HCS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HCS_ASSERT(label, prop, msg)
`define HCS_ASSERT_RST(label, prop, msg)
`endif

`endif

[design/hcs_pkg.sv]
// types, constants and alu functions of the hack cpu step block
`default_nettype none

package hcs_pkg;

   localparam int WORD_W     = 16;
   localparam int MEM_AW     = 16;
   localparam int DATA_DEPTH = 1 << MEM_AW;

   localparam logic [MEM_AW-1:0] MEM_LAST = '1;
   localparam logic [WORD_W-1:0] PLEN_RESET = 16'h8000;

   localparam int BIT_C    = 15;
   localparam int BIT_AM   = 12;
   localparam int BIT_DST_A = 5;
   localparam int BIT_DST_D = 4;
   localparam int BIT_DST_M = 3;

   localparam logic [5:0] ALU_ZERO   = 6'h2A;
   localparam logic [5:0] ALU_ONE    = 6'h3F;
   localparam logic [5:0] ALU_MONE   = 6'h3A;
   localparam logic [5:0] ALU_D      = 6'h0C;
   localparam logic [5:0] ALU_A      = 6'h30;
   localparam logic [5:0] ALU_NOT_D  = 6'h0D;
   localparam logic [5:0] ALU_NOT_A  = 6'h31;
   localparam logic [5:0] ALU_NEG_D  = 6'h0F;
   localparam logic [5:0] ALU_NEG_A  = 6'h33;
   localparam logic [5:0] ALU_D_INC  = 6'h1F;
   localparam logic [5:0] ALU_A_INC  = 6'h37;
   localparam logic [5:0] ALU_D_DEC  = 6'h0E;
   localparam logic [5:0] ALU_A_DEC  = 6'h32;
   localparam logic [5:0] ALU_D_ADD  = 6'h02;
   localparam logic [5:0] ALU_D_SUB  = 6'h13;
   localparam logic [5:0] ALU_A_SUB  = 6'h07;
   localparam logic [5:0] ALU_AND    = 6'h00;
   localparam logic [5:0] ALU_OR     = 6'h15;

   localparam logic [2:0] JMP_NONE = 3'd0;
   localparam logic [2:0] JMP_GT   = 3'd1;
   localparam logic [2:0] JMP_EQ   = 3'd2;
   localparam logic [2:0] JMP_GE   = 3'd3;
   localparam logic [2:0] JMP_LT   = 3'd4;
   localparam logic [2:0] JMP_NE   = 3'd5;
   localparam logic [2:0] JMP_LE   = 3'd6;
   localparam logic [2:0] JMP_ALL  = 3'd7;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] value;
   } hcs_alu_type;

   typedef struct packed {
      logic [WORD_W-1:0] pc;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] d;
      logic              halted;
      logic              illegal;
   } hcs_res_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [MEM_AW-1:0] rd_addr;
      logic              same;
   } hcs_mem_req_type;

   typedef struct packed {
      logic              busy;
      logic [MEM_AW-1:0] addr;
   } hcs_clr_type;

   function automatic hcs_alu_type hcs_alu(input logic [5:0] code,
                                           input logic [WORD_W-1:0] d,
                                           input logic [WORD_W-1:0] am);
      hcs_alu_type r;
      r.ok    = 1'b1;
      r.value = '0;
      case (code)
         ALU_ZERO:  r.value = '0;
         ALU_ONE:   r.value = WORD_W'(1);
         ALU_MONE:  r.value = '1;
         ALU_D:     r.value = d;
         ALU_A:     r.value = am;
         ALU_NOT_D: r.value = ~d;
         ALU_NOT_A: r.value = ~am;
         ALU_NEG_D: r.value = WORD_W'(0) - d;
         ALU_NEG_A: r.value = WORD_W'(0) - am;
         ALU_D_INC: r.value = d + WORD_W'(1);
         ALU_A_INC: r.value = am + WORD_W'(1);
         ALU_D_DEC: r.value = d - WORD_W'(1);
         ALU_A_DEC: r.value = am - WORD_W'(1);
         ALU_D_ADD: r.value = d + am;
         ALU_D_SUB: r.value = d - am;
         ALU_A_SUB: r.value = am - d;
         ALU_AND:   r.value = d & am;
         ALU_OR:    r.value = d | am;
         default:   r.ok = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic hcs_jump(input logic [2:0] cond,
                                     input logic [WORD_W-1:0] v);
      logic neg;
      logic zero;
      logic take;
      neg  = v[WORD_W-1];
      zero = (v == '0);
      case (cond)
         JMP_NONE: take = 1'b0;
         JMP_GT:   take = !neg && !zero;
         JMP_EQ:   take = zero;
         JMP_GE:   take = !neg;
         JMP_LT:   take = neg;
         JMP_NE:   take = !zero;
         JMP_LE:   take = neg || zero;
         JMP_ALL:  take = 1'b1;
         default:  take = 1'b0;
      endcase
      return take;
   endfunction

endpackage

`default_nettype wire

[design/hcs_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module hcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/hcs_clear.sv]
// zeroing sweep of the data memory after reset
`default_nettype none
`include "hack_cpu_step_assert.svh"

module hcs_clear import hcs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   output hcs_clr_type clr
);

   logic              busy_ff, busy_in;
   logic [MEM_AW-1:0] cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + MEM_AW'(1);
         if (cnt_ff == MEM_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign clr.busy = busy_ff;
   assign clr.addr = cnt_ff;

   `HCS_ASSERT_RST(a_clear_after_reset, $past(reset) |-> busy_ff, "sweep not started by reset")

endmodule

`default_nettype wire

[design/hcs_core.sv]
// a, d and pc registers with the alu and jump logic
`default_nettype none
`include "hack_cpu_step_assert.svh"

module hcs_core import hcs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              exec,
   input  wire logic [WORD_W-1:0] instruction,
   input  wire logic [WORD_W-1:0] plen,
   input  wire logic [WORD_W-1:0] am,
   output hcs_res_type            res,
   output hcs_mem_req_type        mreq
);

   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] d_ff, d_in;
   logic [WORD_W-1:0] pc_ff, pc_in;
   logic              run;
   logic              illegal;
   logic              wr_en;
   hcs_alu_type       alu;

   assign run = (pc_ff < plen);
   assign alu = hcs_alu(instruction[11:6], d_ff, instruction[BIT_AM] ? am : a_ff);

   always_comb begin
      a_in    = a_ff;
      d_in    = d_ff;
      pc_in   = pc_ff;
      illegal = 1'b0;
      wr_en   = 1'b0;
      if (run) begin
         pc_in = pc_ff + WORD_W'(1);
         if (!instruction[BIT_C]) begin
            a_in = instruction;
         end else if (alu.ok) begin
            if (instruction[BIT_DST_A]) begin
               a_in = alu.value;
            end
            if (instruction[BIT_DST_D]) begin
               d_in = alu.value;
            end
            wr_en = instruction[BIT_DST_M];
            if (hcs_jump(instruction[2:0], alu.value)) begin
               pc_in = a_ff;
            end
         end else begin
            illegal = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= '0;
         d_ff  <= '0;
         pc_ff <= '0;
      end else if (exec) begin
         a_ff  <= a_in;
         d_ff  <= d_in;
         pc_ff <= pc_in;
      end
   end

   assign res.pc      = pc_in;
   assign res.a       = a_in;
   assign res.d       = d_in;
   assign res.halted  = (pc_in >= plen);
   assign res.illegal = illegal;

   assign mreq.wr_en   = wr_en;
   assign mreq.wr_addr = a_ff[MEM_AW-1:0];
   assign mreq.wr_data = alu.value;
   assign mreq.rd_addr = a_in[MEM_AW-1:0];
   assign mreq.same    = (a_in[MEM_AW-1:0] == a_ff[MEM_AW-1:0]);

   `HCS_ASSERT(a_halted_holds_pc, exec && !run |=> $stable(pc_ff), "pc moved while halted")

endmodule

`default_nettype wire

[design/hack_cpu_step.sv]
// top level of the hack cpu step block
//
//   port group  dir  handshake            word
//   req_        in   req_valid/req_stall  instruction
//   rsp_        out  rsp_valid/rsp_stall  next pc, a, d, m[a], halted, illegal op
//   csr_        in   csr_valid/csr_ready  program length
//
// one instruction per cycle while rsp_stall is low; a result is registered in p_ff when
// its word is taken (execute), then in rsp_ff with m[a] captured from the ram read port
// m[a] is held in a register; a change of a costs one ram read, forwarded next cycle
// reset starts a zeroing sweep of all DATA_DEPTH (65536) words of the data memory,
// with req_stall high throughout; csr writes are taken at any time
// one result may wait on rsp_stall while one more instruction is taken
`default_nettype none
`include "hack_cpu_step_assert.svh"

module hack_cpu_step import hcs_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [WORD_W-1:0]        req_instruction,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [WORD_W-1:0]        rsp_next_pc,
   output      logic signed [WORD_W-1:0] rsp_a_value,
   output      logic signed [WORD_W-1:0] rsp_d_value,
   output      logic signed [WORD_W-1:0] rsp_memory_at_a,
   output      logic                     rsp_halted,
   output      logic                     rsp_illegal_op,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [WORD_W-1:0]        csr_program_length
);

   logic [WORD_W-1:0] plen_ff;
   hcs_clr_type       clr;
   hcs_res_type       res;
   hcs_mem_req_type   mreq;

   logic              item_acc;
   logic              p_go;
   logic [WORD_W-1:0] am_cur;
   logic [WORD_W-1:0] ram_rd_data;
   logic              ram_wr_en;
   logic [MEM_AW-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   logic [WORD_W-1:0] mem_ff, mem_in;
   logic              sel_ff, sel_in;
   logic              p_valid_ff, p_valid_in;
   hcs_res_type       p_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   hcs_res_type       rsp_ff;
   logic [WORD_W-1:0] rsp_mem_ff;

   hcs_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   hcs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .exec        (item_acc),
      .instruction (req_instruction),
      .plen        (plen_ff),
      .am          (am_cur),
      .res         (res),
      .mreq        (mreq)
   );

   assign ram_wr_en   = clr.busy || (item_acc && mreq.wr_en);
   assign ram_wr_addr = clr.busy ? clr.addr : mreq.wr_addr;
   assign ram_wr_data = clr.busy ? '0 : mreq.wr_data;

   hcs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DATA_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (mreq.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign am_cur    = sel_ff ? ram_rd_data : mem_ff;
   assign p_go      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clr.busy || (p_valid_ff && !p_go);
   assign item_acc  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      mem_in = am_cur;
      sel_in = 1'b0;
      if (item_acc) begin
         if (mreq.same) begin
            mem_in = mreq.wr_en ? mreq.wr_data : am_cur;
         end else begin
            sel_in = 1'b1;
         end
      end
   end

   always_comb begin
      p_valid_in   = item_acc || (p_valid_ff && !p_go);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (p_valid_ff && p_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= PLEN_RESET;
         mem_ff       <= '0;
         sel_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            plen_ff <= csr_program_length;
         end
         mem_ff       <= mem_in;
         sel_ff       <= sel_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_acc) begin
         p_ff <= res;
      end
      if (p_valid_ff && p_go) begin
         rsp_ff     <= p_ff;
         rsp_mem_ff <= am_cur;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_ff.pc;
   assign rsp_a_value     = $signed(rsp_ff.a);
   assign rsp_d_value     = $signed(rsp_ff.d);
   assign rsp_memory_at_a = $signed(rsp_mem_ff);
   assign rsp_halted      = rsp_ff.halted;
   assign rsp_illegal_op  = rsp_ff.illegal;

   `HCS_ASSERT(a_fwd_after_exec, sel_ff |-> $past(item_acc), "ram data used without a read")
   `HCS_ASSERT(a_pend_drains, p_valid_ff && !rsp_valid_ff |=> rsp_valid_ff, "pending word lost")
   `HCS_ASSERT(a_no_overrun, item_acc |-> !p_valid_ff || p_go, "pending word overwritten")

endmodule

`default_nettype wire
